// File: src/fdw_pkg.sv
// Shared types and constants for the feature delta window block.
package fdw_pkg;

	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;
	localparam int INDEX_BITS = 7;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH = 2'd0,
		REG_DELTA_WIDTH = 2'd1,
		REG_LEFT_REACH  = 2'd2,
		REG_RIGHT_REACH = 2'd3
	} reg_idx_t;

	localparam logic [7:0] FRAME_WIDTH_RESET = 8'd29;
	localparam logic [7:0] DELTA_WIDTH_RESET = 8'd29;
	localparam logic [2:0] LEFT_REACH_RESET  = 3'd2;
	localparam logic [2:0] RIGHT_REACH_RESET = 3'd2;

	typedef logic [INDEX_BITS-1:0] index_t;

	typedef struct packed {
		logic [7:0] frame_width;
		logic [7:0] delta_width;
		logic [2:0] left_reach;
		logic [2:0] right_reach;
	} cfg_t;

	typedef enum logic [1:0] {
		STEP_CENTER,
		STEP_NEAR,
		STEP_FAR_IN,
		STEP_FAR_OUT
	} read_step_t;

	typedef struct packed {
		logic       valid;
		read_step_t step;
	} tap_t;

	typedef struct packed {
		logic   produce;
		logic   delta_valid;
		logic   last_of_frame;
		index_t element_index;
	} meta_t;

endpackage

// File: src/fdw_in_if.sv
// Input stream interface carrying one feature element per transaction.
interface fdw_in_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          restart;

	modport source (output valid, output sample_value, output restart, input ready);
	modport sink (input valid, input sample_value, input restart, output ready);
endinterface

// File: src/fdw_out_if.sv
// Output stream interface carrying one center/delta result per transaction.
interface fdw_out_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                             valid;
	logic                             ready;
	logic signed [SAMPLE_BITS-1:0]    center_value;
	logic signed [SAMPLE_BITS-1:0]    delta_value;
	logic                             delta_valid;
	logic [fdw_pkg::INDEX_BITS-1:0]   element_index;
	logic                             last_of_frame;

	modport source (
		output valid, output center_value, output delta_value, output delta_valid,
		output element_index, output last_of_frame, input ready
	);
	modport sink (
		input valid, input center_value, input delta_value, input delta_valid,
		input element_index, input last_of_frame, output ready
	);
endinterface

// File: src/fdw_cfg_regs.sv
// APB configuration registers for frame width, delta width and context reach.
module fdw_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fdw_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [fdw_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [fdw_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                pready,
	output fdw_pkg::cfg_t                       cfg
);

	fdw_pkg::reg_idx_t reg_idx;
	fdw_pkg::cfg_t     cfg_q;
	logic              wr;

	assign pready  = 1'b1;
	assign reg_idx = fdw_pkg::reg_idx_t'(paddr[fdw_pkg::CFG_ADDR_BITS-1:2]);
	assign wr      = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= fdw_pkg::FRAME_WIDTH_RESET;
			cfg_q.delta_width <= fdw_pkg::DELTA_WIDTH_RESET;
			cfg_q.left_reach  <= fdw_pkg::LEFT_REACH_RESET;
			cfg_q.right_reach <= fdw_pkg::RIGHT_REACH_RESET;
		end else if (wr) begin
			unique case (reg_idx)
				fdw_pkg::REG_FRAME_WIDTH: cfg_q.frame_width <= pwdata[7:0];
				fdw_pkg::REG_DELTA_WIDTH: cfg_q.delta_width <= pwdata[7:0];
				fdw_pkg::REG_LEFT_REACH:  cfg_q.left_reach  <= pwdata[2:0];
				fdw_pkg::REG_RIGHT_REACH: cfg_q.right_reach <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			fdw_pkg::REG_FRAME_WIDTH: prdata = fdw_pkg::CFG_DATA_BITS'(cfg_q.frame_width);
			fdw_pkg::REG_DELTA_WIDTH: prdata = fdw_pkg::CFG_DATA_BITS'(cfg_q.delta_width);
			fdw_pkg::REG_LEFT_REACH:  prdata = fdw_pkg::CFG_DATA_BITS'(cfg_q.left_reach);
			fdw_pkg::REG_RIGHT_REACH: prdata = fdw_pkg::CFG_DATA_BITS'(cfg_q.right_reach);
		endcase
	end

endmodule

// File: src/fdw_hist_mem.sv
// Frame history memory with one registered read port and one write port.
module fdw_hist_mem #(
	parameter int DATA_BITS = 16,
	parameter int ADDR_BITS = 10
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data_q,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// File: src/fdw_ctrl.sv
// Frame counters, history read sequencer and result credit tracking.
module fdw_ctrl #(
	parameter int MAX_FRAME_WIDTH = 128,
	parameter int MAX_HISTORY_FRAMES = 8,
	parameter int SAMPLE_BITS = 16,
	localparam int EW = $clog2(MAX_FRAME_WIDTH),
	localparam int SLB = $clog2(MAX_HISTORY_FRAMES),
	localparam int AW = SLB + EW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fdw_pkg::cfg_t          cfg,
	fdw_in_if.sink                 feat,
	input  logic                   out_fire,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [SAMPLE_BITS-1:0] wr_data,
	output fdw_pkg::tap_t          tap_s1,
	output fdw_pkg::meta_t         meta_s1,
	output logic [SAMPLE_BITS-1:0] x_s1
);

	localparam int FWB = $clog2(MAX_FRAME_WIDTH + 1);
	localparam int CW = (FWB > 8) ? FWB : 8;
	localparam int REACH_CAP = (MAX_HISTORY_FRAMES / 2 > 4) ? 4 : MAX_HISTORY_FRAMES / 2;
	localparam int STB = $clog2(MAX_HISTORY_FRAMES + 1);
	localparam int SCW = (STB > 4) ? STB : 4;
	localparam int DW = (SLB + 2 > 4) ? SLB + 2 : 4;

	logic [EW-1:0]                 elem_q;
	logic [SCW-1:0]                stored_q;
	logic [SLB-1:0]                slot_q;
	logic                          busy_q, busy_d;
	fdw_pkg::read_step_t           step_q, step_d;
	logic [fdw_pkg::OUT_CNT_BITS-1:0] credit_q;

	logic [SAMPLE_BITS-1:0]        x_q;
	logic [EW-1:0]                 eidx_q;
	logic [SLB-1:0]                slot_item_q;
	logic [3:0]                    span_q;
	logic [2:0]                    rr_q;
	fdw_pkg::meta_t                meta_q;

	logic [2:0]     lr, rr;
	logic [3:0]     span;
	logic [CW-1:0]  fw_raw, fw_eff, dw_raw, dw_eff, e_ext, e_clip, lo_bound;
	logic [EW-1:0]  e_idx;
	logic [SCW-1:0] stored_cur;
	logic [SLB-1:0] slot_inc;
	logic           last, dv, produce, accept, item_done;
	logic [3:0]     k;
	logic [DW-1:0]  back_sum;
	logic [SLB-1:0] back_slot;

	always_comb begin
		if (cfg.left_reach == 3'd0) begin
			lr = 3'd1;
		end else if (cfg.left_reach > 3'(REACH_CAP)) begin
			lr = 3'(REACH_CAP);
		end else begin
			lr = cfg.left_reach;
		end
		if (cfg.right_reach == 3'd0) begin
			rr = 3'd1;
		end else if (cfg.right_reach > 3'(REACH_CAP)) begin
			rr = 3'(REACH_CAP);
		end else begin
			rr = cfg.right_reach;
		end
		span = 4'(lr) + 4'(rr);
	end

	always_comb begin
		fw_raw = CW'(cfg.frame_width);
		if (fw_raw == '0) begin
			fw_eff = CW'(1);
		end else if (fw_raw > CW'(MAX_FRAME_WIDTH)) begin
			fw_eff = CW'(MAX_FRAME_WIDTH);
		end else begin
			fw_eff = fw_raw;
		end
		dw_raw     = CW'(cfg.delta_width);
		dw_eff     = (dw_raw > fw_eff) ? fw_eff : dw_raw;
		stored_cur = feat.restart ? '0 : stored_q;
		e_ext      = feat.restart ? '0 : CW'(elem_q);
		e_clip     = (e_ext >= fw_eff) ? fw_eff - CW'(1) : e_ext;
		e_idx      = e_clip[EW-1:0];
		last       = (e_clip == fw_eff - CW'(1));
		lo_bound   = fw_eff - dw_eff;
		dv         = (e_clip >= lo_bound);
		produce    = (stored_cur >= SCW'(span));
		slot_inc   = (slot_q == SLB'(MAX_HISTORY_FRAMES - 1)) ? '0 : slot_q + SLB'(1);
	end

	assign item_done  = busy_q && (step_q == fdw_pkg::STEP_FAR_OUT);
	assign feat.ready = (!busy_q || item_done) &&
		(credit_q < fdw_pkg::OUT_CNT_BITS'(fdw_pkg::OUT_DEPTH));
	assign accept     = feat.valid && feat.ready;

	always_comb begin
		busy_d = busy_q;
		step_d = step_q;
		if (accept) begin
			busy_d = 1'b1;
			step_d = fdw_pkg::STEP_CENTER;
		end else if (busy_q) begin
			unique case (step_q)
				fdw_pkg::STEP_CENTER:  step_d = fdw_pkg::STEP_NEAR;
				fdw_pkg::STEP_NEAR:    step_d = fdw_pkg::STEP_FAR_IN;
				fdw_pkg::STEP_FAR_IN:  step_d = fdw_pkg::STEP_FAR_OUT;
				fdw_pkg::STEP_FAR_OUT: busy_d = 1'b0;
			endcase
		end
	end

	always_comb begin
		unique case (step_q)
			fdw_pkg::STEP_CENTER:  k = 4'(rr_q);
			fdw_pkg::STEP_NEAR:    k = 4'd1;
			fdw_pkg::STEP_FAR_IN:  k = span_q - 4'd1;
			fdw_pkg::STEP_FAR_OUT: k = span_q;
		endcase
		back_sum  = DW'(slot_item_q) + DW'(MAX_HISTORY_FRAMES) - DW'(k);
		back_slot = (back_sum >= DW'(MAX_HISTORY_FRAMES)) ?
			SLB'(back_sum - DW'(MAX_HISTORY_FRAMES)) : SLB'(back_sum);
		rd_en     = busy_q;
		rd_addr   = {back_slot, eidx_q};
		wr_en     = item_done;
		wr_addr   = {slot_item_q, eidx_q};
		wr_data   = x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q       <= '0;
			stored_q     <= '0;
			slot_q       <= '0;
			busy_q       <= 1'b0;
			step_q       <= fdw_pkg::STEP_CENTER;
			credit_q     <= '0;
			tap_s1.valid <= 1'b0;
			tap_s1.step  <= fdw_pkg::STEP_CENTER;
		end else begin
			busy_q       <= busy_d;
			step_q       <= step_d;
			tap_s1.valid <= busy_q;
			tap_s1.step  <= step_q;
			if (accept) begin
				if (last) begin
					elem_q <= '0;
					slot_q <= slot_inc;
					stored_q <= (stored_cur < SCW'(MAX_HISTORY_FRAMES)) ?
						stored_cur + SCW'(1) : stored_cur;
				end else begin
					elem_q   <= e_idx + EW'(1);
					stored_q <= stored_cur;
				end
			end
			unique case ({accept && produce, out_fire})
				2'b10:   credit_q <= credit_q + fdw_pkg::OUT_CNT_BITS'(1);
				2'b01:   credit_q <= credit_q - fdw_pkg::OUT_CNT_BITS'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q                  <= feat.sample_value;
			eidx_q               <= e_idx;
			slot_item_q          <= slot_q;
			span_q               <= span;
			rr_q                 <= rr;
			meta_q.produce       <= produce;
			meta_q.delta_valid   <= dv;
			meta_q.last_of_frame <= last;
			meta_q.element_index <= fdw_pkg::index_t'(e_idx);
		end
		if (item_done) begin
			meta_s1 <= meta_q;
			x_s1    <= x_q;
		end
	end

endmodule

// File: src/fdw_delta.sv
// Delta arithmetic pipeline with divide-by-ten and the output result queue.
module fdw_delta #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fdw_pkg::tap_t          tap_s1,
	input  fdw_pkg::meta_t         meta_s1,
	input  logic [SAMPLE_BITS-1:0] x_s1,
	input  logic [SAMPLE_BITS-1:0] rd_data,
	fdw_out_if.source              result
);

	localparam int SB = SAMPLE_BITS;
	localparam int NB = SB + 2;
	localparam int NW = SB + 3;
	localparam int SHIFT = SB + 6;
	localparam int MW = SB + 3;
	localparam int H = (MW + 1) / 2;
	localparam int PLW = NB + H;
	localparam int PW = NB + MW;
	localparam int QB = PW - SHIFT;
	localparam int IB = fdw_pkg::INDEX_BITS;
	localparam int EB = 2 * SB + 2 + IB;
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'd9) / 64'd10;
	localparam logic [H-1:0] MLO = RECIP[H-1:0];
	localparam logic [MW-H-1:0] MHI = RECIP[MW-1:H];

	logic signed [SB-1:0] center_q, near_q, far_in_q;
	logic signed [SB-1:0] xa, dd;
	logic signed [NW-1:0] num, mag;
	logic [NB-1:0]        n_s1;
	logic                 fire_s1;

	logic                 v_s2, v_s3, v_s4;
	logic [NB-1:0]        n_s2, n_s3;
	logic                 neg_s2, neg_s3, neg_s4;
	logic [SB-1:0]        center_s2, center_s3, center_s4;
	fdw_pkg::meta_t       meta_s2, meta_s3, meta_s4;
	logic [PLW-1:0]       pl_s3;
	logic [PW-1:0]        prod_s4;

	logic [QB-1:0]        quot;
	logic [SB-1:0]        qext, dval;
	logic [EB-1:0]        entry_in, head;
	logic [EB-1:0]        fifo_q [fdw_pkg::OUT_DEPTH];
	logic [fdw_pkg::OUT_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [fdw_pkg::OUT_CNT_BITS-1:0] count_q;
	logic                 push, pop;

	always_ff @(posedge clk) begin
		if (tap_s1.valid) begin
			unique case (tap_s1.step)
				fdw_pkg::STEP_CENTER:  center_q <= rd_data;
				fdw_pkg::STEP_NEAR:    near_q   <= rd_data;
				fdw_pkg::STEP_FAR_IN:  far_in_q <= rd_data;
				fdw_pkg::STEP_FAR_OUT: ;
			endcase
		end
	end

	always_comb begin
		xa      = $signed(x_s1);
		dd      = $signed(rd_data);
		num     = ((NW'(xa) - NW'(dd)) <<< 1) + (NW'(near_q) - NW'(far_in_q));
		mag     = num[NW-1] ? -num : num;
		n_s1    = mag[NB-1:0] + NB'(5);
		fire_s1 = tap_s1.valid && (tap_s1.step == fdw_pkg::STEP_FAR_OUT) && meta_s1.produce;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= fire_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		n_s2      <= n_s1;
		neg_s2    <= num[NW-1];
		center_s2 <= center_q;
		meta_s2   <= meta_s1;

		pl_s3     <= PLW'(n_s2) * PLW'(MLO);
		n_s3      <= n_s2;
		neg_s3    <= neg_s2;
		center_s3 <= center_s2;
		meta_s3   <= meta_s2;

		prod_s4   <= PW'(pl_s3) + ((PW'(n_s3) * PW'(MHI)) << H);
		neg_s4    <= neg_s3;
		center_s4 <= center_s3;
		meta_s4   <= meta_s3;
	end

	// The rounded quotient stays below half the sample range, so no saturation is needed.
	always_comb begin
		quot = prod_s4[PW-1:SHIFT];
		qext = {1'b0, quot};
		if (!meta_s4.delta_valid) begin
			dval = '0;
		end else if (neg_s4) begin
			dval = -qext;
		end else begin
			dval = qext;
		end
		entry_in = {center_s4, dval, meta_s4.delta_valid, meta_s4.element_index,
			meta_s4.last_of_frame};
	end

	assign push = v_s4;
	assign pop  = result.valid && result.ready;
	assign head = fifo_q[rd_ptr_q];

	assign result.valid         = (count_q != '0);
	assign result.center_value  = head[EB-1 -: SB];
	assign result.delta_value   = head[EB-SB-1 -: SB];
	assign result.delta_valid   = head[IB+1];
	assign result.element_index = head[IB:1];
	assign result.last_of_frame = head[0];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + fdw_pkg::OUT_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fdw_pkg::OUT_PTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + fdw_pkg::OUT_CNT_BITS'(1);
				2'b01:   count_q <= count_q - fdw_pkg::OUT_CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/feature_delta_window_top.sv
// Top level of the feature delta window block.
// Feature elements enter one per transaction on feat and are written into a frame history
// memory holding MAX_HISTORY_FRAMES frame slots. Each element occupies the history memory's
// read port for four read steps (center frame, newest past frame, and the two oldest frames of
// the window), so while busy a new element is accepted only in the last step of the current one;
// that step also writes the element and overlaps the acceptance of the next one. A result is
// offered on result after the delta pipeline registers and passes through a four-entry output
// queue; the input stalls while four results are owed and not yet taken. The history memory
// is not cleared after reset; the frame count keeps unwritten entries out of every result.
module feature_delta_window_top #(
	parameter int MAX_FRAME_WIDTH = 128,
	parameter int MAX_HISTORY_FRAMES = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	fdw_in_if.sink                            feat,
	fdw_out_if.source                         result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fdw_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [fdw_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [fdw_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                              pready
);

	localparam int ADDR_BITS = $clog2(MAX_HISTORY_FRAMES) + $clog2(MAX_FRAME_WIDTH);

	fdw_pkg::cfg_t          cfg;
	fdw_pkg::tap_t          tap_s1;
	fdw_pkg::meta_t         meta_s1;
	logic [SAMPLE_BITS-1:0] x_s1;
	logic                   rd_en, wr_en;
	logic [ADDR_BITS-1:0]   rd_addr, wr_addr;
	logic [SAMPLE_BITS-1:0] wr_data, rd_data;
	logic                   out_fire;

	assign out_fire = result.valid && result.ready;

	fdw_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fdw_ctrl #(
		.MAX_FRAME_WIDTH    (MAX_FRAME_WIDTH),
		.MAX_HISTORY_FRAMES (MAX_HISTORY_FRAMES),
		.SAMPLE_BITS        (SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.feat     (feat),
		.out_fire (out_fire),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.tap_s1   (tap_s1),
		.meta_s1  (meta_s1),
		.x_s1     (x_s1)
	);

	fdw_hist_mem #(
		.DATA_BITS (SAMPLE_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_hist_mem (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	fdw_delta #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_delta (
		.clk     (clk),
		.arst_n  (arst_n),
		.tap_s1  (tap_s1),
		.meta_s1 (meta_s1),
		.x_s1    (x_s1),
		.rd_data (rd_data),
		.result  (result)
	);

endmodule

// File: sim/feature_delta_window_top_tb.sv
// Testbench for feature_delta_window_top: streams frames, predicts results and checks them.
`timescale 1ns / 1ps

module feature_delta_window_top_tb;

	localparam int MAX_FRAME_WIDTH = 128;
	localparam int HISTORY_FRAMES = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT = 50000;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] center_value;
		logic signed [SAMPLE_BITS-1:0] delta_value;
		logic                          delta_valid;
		fdw_pkg::index_t               element_index;
		logic                          last_of_frame;
	} result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [fdw_pkg::CFG_ADDR_BITS-1:0] paddr;
	logic [fdw_pkg::CFG_DATA_BITS-1:0] pwdata;
	logic [fdw_pkg::CFG_DATA_BITS-1:0] prdata;
	logic pready;

	fdw_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) feat ();
	fdw_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result ();

	feature_delta_window_top #(
		.MAX_FRAME_WIDTH(MAX_FRAME_WIDTH),
		.MAX_HISTORY_FRAMES(HISTORY_FRAMES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.feat(feat),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic signed [SAMPLE_BITS-1:0] frame_store [HISTORY_FRAMES][MAX_FRAME_WIDTH];
	int            elem_pos;
	int            frames_done;
	int            write_slot;
	fdw_pkg::cfg_t shadow_cfg;

	result_t results_due [$];
	int      error_count;
	bit      quiet_mode;
	int      hold_off_left;
	int      rx_gap;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet_mode) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return 16'sh0000;
			3: return -16'sh0001;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic int effective_reach(input logic [2:0] reach);
		int v;
		int cap;
		v = reach;
		cap = (HISTORY_FRAMES / 2 > 4) ? 4 : HISTORY_FRAMES / 2;
		if (v < 1) v = 1;
		if (v > cap) v = cap;
		return v;
	endfunction

	function automatic int slot_back(input int k);
		return (write_slot + HISTORY_FRAMES - (k % HISTORY_FRAMES)) % HISTORY_FRAMES;
	endfunction

	// Models one accepted element: computes its result, if any, then stores the element.
	function automatic void predict_element(input logic signed [SAMPLE_BITS-1:0] x,
		input logic new_utt);
		int fw;
		int dw;
		int span;
		int rr;
		int e;
		int num;
		int q;
		int smax;
		int smin;
		logic last;
		result_t r;
		smax = (1 << (SAMPLE_BITS - 1)) - 1;
		smin = -smax - 1;
		fw = shadow_cfg.frame_width;
		if (fw < 1) fw = 1;
		if (fw > MAX_FRAME_WIDTH) fw = MAX_FRAME_WIDTH;
		dw = (shadow_cfg.delta_width > fw) ? fw : shadow_cfg.delta_width;
		rr = effective_reach(shadow_cfg.right_reach);
		span = effective_reach(shadow_cfg.left_reach) + rr;
		if (new_utt) begin
			frames_done = 0;
			elem_pos = 0;
		end
		e = elem_pos;
		if (e >= fw) e = fw - 1;
		last = (e == fw - 1);
		if (frames_done >= span) begin
			r.center_value = frame_store[slot_back(rr)][e];
			r.delta_valid = (e >= fw - dw);
			r.delta_value = '0;
			if (r.delta_valid) begin
				num = 2 * (int'(x) - int'(frame_store[slot_back(span)][e]))
					+ (int'(frame_store[slot_back(1)][e])
					- int'(frame_store[slot_back(span - 1)][e]));
				q = (num >= 0) ? (num + 5) / 10 : -((-num + 5) / 10);
				if (q > smax) q = smax;
				if (q < smin) q = smin;
				r.delta_value = q[SAMPLE_BITS-1:0];
			end
			r.element_index = e[fdw_pkg::INDEX_BITS-1:0];
			r.last_of_frame = last;
			results_due.push_back(r);
		end
		frame_store[write_slot][e] = x;
		if (last) begin
			elem_pos = 0;
			write_slot = (write_slot + 1) % HISTORY_FRAMES;
			if (frames_done < HISTORY_FRAMES) frames_done++;
		end else begin
			elem_pos = e + 1;
		end
	endfunction

	task automatic send_element(input logic signed [SAMPLE_BITS-1:0] value, input logic new_utt);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			feat.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		feat.valid = 1'b1;
		feat.sample_value = value;
		feat.restart = new_utt;
		do @(posedge clk); while (!feat.ready);
		predict_element(value, new_utt);
	endtask

	task automatic wait_results_drained();
		int waited;
		waited = 0;
		while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (results_due.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived", results_due.size()));
			results_due.delete();
		end
	endtask

	task automatic settle_block();
		@(negedge clk);
		feat.valid = 1'b0;
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input fdw_pkg::reg_idx_t idx,
		input logic [fdw_pkg::CFG_DATA_BITS-1:0] value);
		logic [fdw_pkg::CFG_DATA_BITS-1:0] want;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = fdw_pkg::CFG_ADDR_BITS'(idx) << 2;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			fdw_pkg::REG_FRAME_WIDTH: shadow_cfg.frame_width = value[7:0];
			fdw_pkg::REG_DELTA_WIDTH: shadow_cfg.delta_width = value[7:0];
			fdw_pkg::REG_LEFT_REACH:  shadow_cfg.left_reach = value[2:0];
			fdw_pkg::REG_RIGHT_REACH: shadow_cfg.right_reach = value[2:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == fdw_pkg::REG_LEFT_REACH || idx == fdw_pkg::REG_RIGHT_REACH) begin
			want = value & 32'h7;
		end else begin
			want = value & 32'hFF;
		end
		if (prdata !== want) begin
			report_mismatch($sformatf("register %s read 0x%0h, wrote 0x%0h",
				idx.name(), prdata, want));
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure_block(input int fw, input int dw, input int lr, input int rr);
		write_reg(fdw_pkg::REG_FRAME_WIDTH, fw);
		write_reg(fdw_pkg::REG_DELTA_WIDTH, dw);
		write_reg(fdw_pkg::REG_LEFT_REACH, lr);
		write_reg(fdw_pkg::REG_RIGHT_REACH, rr);
	endtask

	// Result side: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				result.ready = 1'b0;
				hold_off_left--;
			end else if (rx_gap > 0) begin
				result.ready = 1'b0;
				rx_gap--;
			end else begin
				result.ready = 1'b1;
				rx_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result transaction, index %0d",
					result.element_index));
			end else begin
				want = results_due.pop_front();
				if (result.center_value !== want.center_value)
					report_mismatch($sformatf("center_value %0d, expected %0d (index %0d)",
						result.center_value, want.center_value, want.element_index));
				if (result.delta_value !== want.delta_value)
					report_mismatch($sformatf("delta_value %0d, expected %0d (index %0d)",
						result.delta_value, want.delta_value, want.element_index));
				if (result.delta_valid !== want.delta_valid)
					report_mismatch($sformatf("delta_valid %b, expected %b (index %0d)",
						result.delta_valid, want.delta_valid, want.element_index));
				if (result.element_index !== want.element_index)
					report_mismatch($sformatf("element_index %0d, expected %0d",
						result.element_index, want.element_index));
				if (result.last_of_frame !== want.last_of_frame)
					report_mismatch($sformatf("last_of_frame %b, expected %b (index %0d)",
						result.last_of_frame, want.last_of_frame, want.element_index));
			end
		end
	end

	task automatic test_reset_config();
		for (int i = 0; i < 4 * 29 + 6; i++) begin
			send_element(random_sample(), 1'b0);
		end
		settle_block();
	endtask

	task automatic test_register_access();
		write_reg(fdw_pkg::REG_FRAME_WIDTH, 32'd0);
		write_reg(fdw_pkg::REG_FRAME_WIDTH, 32'hFFFF_FFFF);
		write_reg(fdw_pkg::REG_DELTA_WIDTH, 32'd0);
		write_reg(fdw_pkg::REG_DELTA_WIDTH, 32'hFFFF_FFFF);
		write_reg(fdw_pkg::REG_LEFT_REACH, 32'd0);
		write_reg(fdw_pkg::REG_LEFT_REACH, 32'hFFFF_FFFF);
		write_reg(fdw_pkg::REG_RIGHT_REACH, 32'd0);
		write_reg(fdw_pkg::REG_RIGHT_REACH, 32'hFFFF_FFFF);
	endtask

	task automatic test_extremes();
		logic signed [SAMPLE_BITS-1:0] pattern [10];
		pattern = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, -16'sh8000,
			16'sh7FFF, 16'sh0001, 16'sh0005, 16'sh7FFF, 16'sh7FFF};
		configure_block(2, 2, 1, 1);
		for (int i = 0; i < 10; i++) begin
			send_element(pattern[i], i == 0);
		end
		// A restart in the middle of a frame drops back to warm-up.
		send_element(-16'sh8000, 1'b0);
		for (int i = 0; i < 6; i++) begin
			send_element(random_sample(), i == 0);
		end
		settle_block();
	endtask

	task automatic test_delta_slice();
		configure_block(3, 1, 2, 1);
		for (int i = 0; i < 12; i++) begin
			send_element(random_sample(), i == 0);
		end
		settle_block();
		write_reg(fdw_pkg::REG_DELTA_WIDTH, 0);
		for (int i = 0; i < 3; i++) begin
			send_element(random_sample(), 1'b0);
		end
		settle_block();
	endtask

	task automatic test_width_clamps();
		configure_block(0, 255, 0, 7);
		for (int i = 0; i < 8; i++) begin
			send_element(random_sample(), i == 0);
		end
		settle_block();
	endtask

	task automatic test_shrink_mid_frame();
		configure_block(4, 4, 1, 1);
		for (int i = 0; i < 15; i++) begin
			send_element(random_sample(), i == 0);
		end
		settle_block();
		write_reg(fdw_pkg::REG_FRAME_WIDTH, 2);
		for (int i = 0; i < 5; i++) begin
			send_element(random_sample(), 1'b0);
		end
		settle_block();
	endtask

	task automatic test_backpressure();
		configure_block(4, 4, 1, 1);
		for (int i = 0; i < 8; i++) begin
			send_element(random_sample(), i == 0);
		end
		quiet_mode = 1'b1;
		hold_off_left = 300;
		for (int i = 0; i < 24; i++) begin
			send_element(random_sample(), 1'b0);
		end
		quiet_mode = 1'b0;
		for (int i = 0; i < 8; i++) begin
			send_element(random_sample(), 1'b0);
		end
		@(negedge clk);
		feat.valid = 1'b0;
		wait_results_drained();
		for (int i = 0; i < 8; i++) begin
			send_element(random_sample(), 1'b0);
		end
		settle_block();
	endtask

	task automatic test_wide_frames();
		configure_block(255, 128, 0, 1);
		for (int i = 0; i < 2 * MAX_FRAME_WIDTH + 4; i++) begin
			send_element(random_sample(), i == 0);
		end
		settle_block();
	endtask

	task automatic test_random_phases();
		int fw;
		int dw;
		int lr;
		int rr;
		int frames;
		int pick;
		int items_done;
		items_done = 0;
		while (items_done < 40) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				fw = $urandom_range(1, 6);
			end else if (pick < 95) begin
				fw = $urandom_range(7, 20);
			end else begin
				fw = $urandom_range(21, 40);
			end
			lr = $urandom_range(0, 7);
			rr = $urandom_range(0, 7);
			dw = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, fw + 2);
			configure_block(fw, dw, lr, rr);
			frames = effective_reach(3'(lr)) + effective_reach(3'(rr)) + $urandom_range(2, 5);
			quiet_mode = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < fw * frames; i++) begin
				send_element(random_sample(), i == 0 || $urandom_range(0, 99) < 2);
			end
			quiet_mode = 1'b0;
			items_done += fw * frames;
			settle_block();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		feat.valid = 1'b0;
		feat.sample_value = '0;
		feat.restart = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		error_count = 0;
		quiet_mode = 1'b0;
		hold_off_left = 0;
		rx_gap = 0;
		elem_pos = 0;
		frames_done = 0;
		write_slot = 0;
		shadow_cfg.frame_width = fdw_pkg::FRAME_WIDTH_RESET;
		shadow_cfg.delta_width = fdw_pkg::DELTA_WIDTH_RESET;
		shadow_cfg.left_reach = fdw_pkg::LEFT_REACH_RESET;
		shadow_cfg.right_reach = fdw_pkg::RIGHT_REACH_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_register_access();
		test_extremes();
		test_delta_slice();
		test_width_clamps();
		test_shrink_mid_frame();
		test_backpressure();
		test_wide_frames();
		test_random_phases();

		settle_block();
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/fdw_pkg.sv
src/fdw_in_if.sv
src/fdw_out_if.sv
src/fdw_cfg_regs.sv
src/fdw_hist_mem.sv
src/fdw_ctrl.sv
src/fdw_delta.sv
src/feature_delta_window_top.sv
sim/feature_delta_window_top_tb.sv
